### hw/rtl/alv_pkg.sv
package alv_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned PIXEL_W  = 24;
  localparam int unsigned SUM_W    = 16;

  // block length and its counter
  localparam int unsigned SAMPLES  = 11;
  localparam int unsigned CNT_W    = $clog2(SAMPLES + 1);

  // reciprocal of SAMPLES for the block mean, exact for any block sum
  localparam int unsigned MEAN_SHIFT   = 20;
  localparam int unsigned MEAN_RECIP_W = MEAN_SHIFT + 1 - $clog2(SAMPLES);
  localparam int unsigned MEAN_PROD_W  = SUM_W + MEAN_RECIP_W;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP =
    MEAN_RECIP_W'((2**MEAN_SHIFT + SAMPLES - 1) / SAMPLES);

  // calibration window and brightness reset values
  localparam logic [SAMPLE_W-1:0] WINDOW_LOW_RST  = 12'd2400;
  localparam logic [SAMPLE_W-1:0] WINDOW_HIGH_RST = 12'd3100;
  localparam logic [COLOR_W-1:0]  COLOR_LOW_RST   = 8'd5;
  localparam logic [COLOR_W-1:0]  COLOR_HIGH_RST  = 8'd60;

  // shared divider: 20-bit dividend, 12-bit divisor, one bit per step
  localparam int unsigned DIV_N_W  = SAMPLE_W + COLOR_W;
  localparam int unsigned DIV_D_W  = SAMPLE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

  // stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_HIGH = 1'd1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN,
    S_WIN,
    S_RMUL,
    S_RGO,
    S_RDIV,
    S_GMUL,
    S_GGO,
    S_GDIV,
    S_DONE
  } alv_state_t;

  // divider request
  typedef struct packed {
    logic                 start;
    logic [DIV_N_W-1:0]   dividend;
    logic [DIV_D_W-1:0]   divisor;
  } alv_div_req_t;

endpackage

### hw/rtl/alv_div.sv
module alv_div
  import alv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  alv_div_req_t       req,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   divisor_r, divisor_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  // one restoring step: shift in the next dividend bit and try to subtract
  assign trial = {rem_r, quo_r[DIV_N_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign fits  = trial >= {1'b0, divisor_r};

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    divisor_nxt = divisor_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      rem_nxt     = '0;
      quo_nxt     = req.dividend;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_nxt = {quo_r[DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    divisor_r <= divisor_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/autoranging_level_to_color.sv
// Auto-ranging level to color converter.
// in_*: one 12-bit sample per request. Every SAMPLES-th sample closes a
// block; the block's truncated mean widens the calibration window if it lies
// outside it and is mapped to a red and a green brightness.
// out_*: one request per block carrying mean, red, green and the GRB pixel.
// cfg_*: write-only registers color_low (index 0) and color_high (index 1); the user
// must write them only while no block is in flight, which the block does not enforce.
// A sample that does not close a block is taken at once while the sequencer is idle.
// The closing sample starts the block's work: a reciprocal multiply for the mean,
// then two 20-step passes of the shared bit-serial divider (red, green) with their
// setup cycles; in_tready is low meanwhile. The result sits in an output register,
// so samples of the next block are taken while it waits for out_tready; a stalled
// receiver only holds the sequencer once the next block's result is ready.
// Reset (rst_n low, synchronous) clears the sum and count, sets the window
// to 2400..3100 and the brightness registers to 5 and 60.
module autoranging_level_to_color
  import alv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] sample
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [11:0] mean_level, [19:12] red_level,
                                            // [27:20] green_level, [51:28] pixel_word
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COLOR_W-1:0]    cfg_wdata
);

  alv_state_t state_r, state_nxt;

  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SAMPLE_W-1:0] wl_r, wh_r;
  logic [COLOR_W-1:0]  cl_r, ch_r;
  logic [SAMPLE_W-1:0] mean_r;
  logic [SAMPLE_W-1:0] width_r;
  logic [DIV_N_W-1:0]  prod_r;
  logic [COLOR_W-1:0]  red_r, green_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                in_req;
  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]    cnt_inc;
  logic                last_sample;
  logic [MEAN_PROD_W-1:0] mean_prod;
  logic                span_neg;
  logic [COLOR_W-1:0]  span_mag;
  logic [SAMPLE_W-1:0] win_dist;
  logic [COLOR_W-1:0]  scaled;
  logic                load_out;
  alv_div_req_t        div_req;
  logic                div_done;
  logic [DIV_N_W-1:0]  div_quo;

  assign in_req      = in_tvalid && in_tready;
  assign sum_add     = sum_r + SUM_W'(in_tdata[SAMPLE_W-1:0]);
  assign cnt_inc     = cnt_r + 1'b1;
  assign last_sample = cnt_inc == CNT_W'(SAMPLES);

  // block mean by reciprocal multiply
  assign mean_prod = MEAN_PROD_W'(sum_r) * MEAN_PROD_W'(MEAN_RECIP);

  // signed color span as sign and magnitude
  assign span_neg = ch_r < cl_r;
  assign span_mag = span_neg ? cl_r - ch_r : ch_r - cl_r;

  // distance from the top for red, from the bottom for green
  assign win_dist = (state_r == S_RMUL) ? wh_r - mean_r : mean_r - wl_r;

  // quotient magnitude never exceeds the span, so eight bits suffice
  always_comb begin
    if (width_r == '0) begin
      scaled = cl_r;
    end else if (span_neg) begin
      scaled = cl_r - div_quo[COLOR_W-1:0];
    end else begin
      scaled = cl_r + div_quo[COLOR_W-1:0];
    end
  end

  // shared divider operands: product by window width
  assign div_req.start    = (state_r == S_RGO) || (state_r == S_GGO);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = width_r;

  alv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && last_sample) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: state_nxt = S_WIN;
      S_WIN:  state_nxt = S_RMUL;
      S_RMUL: state_nxt = S_RGO;
      S_RGO:  state_nxt = S_RDIV;
      S_RDIV: if (div_done) state_nxt = S_GMUL;
      S_GMUL: state_nxt = S_GGO;
      S_GGO:  state_nxt = S_GDIV;
      S_GDIV: if (div_done) state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // accumulator, window and brightness registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      wl_r  <= WINDOW_LOW_RST;
      wh_r  <= WINDOW_HIGH_RST;
      cl_r  <= COLOR_LOW_RST;
      ch_r  <= COLOR_HIGH_RST;
    end else begin
      if (in_req) begin
        sum_r <= sum_add;
        cnt_r <= last_sample ? '0 : cnt_inc;
      end
      if (state_r == S_MEAN) begin
        sum_r <= '0;
      end
      // widen the window to hold the new mean
      if (state_r == S_WIN) begin
        if (mean_r < wl_r) begin
          wl_r <= mean_r;
        end else if (mean_r > wh_r) begin
          wh_r <= mean_r;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLOR_LOW:  cl_r <= cfg_wdata;
          CFG_COLOR_HIGH: ch_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_MEAN) begin
      mean_r <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
    end
    if (state_r == S_RMUL || state_r == S_GMUL) begin
      prod_r <= DIV_N_W'(win_dist) * DIV_N_W'(span_mag);
    end
    if (state_r == S_RMUL) begin
      width_r <= wh_r - wl_r;
    end
    if (state_r == S_RDIV && div_done) begin
      red_r <= scaled;
    end
    if (state_r == S_GDIV && div_done) begin
      green_r <= scaled;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {4'd0, green_r, red_r, 8'd0, green_r, red_r, mean_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hw/rtl/alv_checker.sv
module alv_checker
  import alv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tready,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // the pixel word repeats green and red with blue zero
  a_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[51:44] == out_tdata[27:20] &&
                   out_tdata[43:36] == out_tdata[19:12] &&
                   out_tdata[35:28] == 8'd0 && out_tdata[55:52] == 4'd0)
    else $error("pixel word does not match brightnesses");

  // nothing is offered right after reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // a new result is loaded only while the input side is held off
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a block in flight");

endmodule

bind autoranging_level_to_color alv_checker u_alv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/autoranging_level_to_color_tb.sv
module autoranging_level_to_color_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned COLOR_MAX = (1 << COLOR_W) - 1;

  // one expected result
  typedef struct {
    logic [SAMPLE_W-1:0] mean;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [PIXEL_W-1:0]  pixel;
  } pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COLOR_W-1:0]    cfg_wdata;

  // predictor state
  logic [SUM_W-1:0]    acc_sum;
  logic [CNT_W-1:0]    acc_count;
  logic [SAMPLE_W-1:0] win_lo;
  logic [SAMPLE_W-1:0] win_hi;
  logic [COLOR_W-1:0]  color_lo;
  logic [COLOR_W-1:0]  color_hi;

  pixel_t pending_pixels[$];

  bit          no_gaps;
  int unsigned cycles;
  int unsigned samples_sent;
  int unsigned pixels_checked;
  int unsigned pixel_errors;
  int unsigned color_settings;

  autoranging_level_to_color dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // brightness for a distance into the window, truncated toward zero
  function automatic logic [COLOR_W-1:0] scaled_color(input int offset, input int width);
    int span;
    int q;
    span = int'(color_hi) - int'(color_lo);
    if (width == 0) return color_lo;
    q = (offset * span) / width + int'(color_lo);
    return q[COLOR_W-1:0];
  endfunction

  // accumulate one sample; a closing sample yields one expected pixel
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] mean;
    int width;
    pixel_t p;
    acc_sum = acc_sum + SUM_W'(s);
    acc_count = acc_count + 1'b1;
    if (acc_count < SAMPLES) return;
    mean = SAMPLE_W'(acc_sum / SAMPLES);
    acc_sum = '0;
    acc_count = '0;
    // window only ever widens toward the mean
    if (mean < win_lo) win_lo = mean;
    else if (mean > win_hi) win_hi = mean;
    width = int'(win_hi) - int'(win_lo);
    p.mean = mean;
    p.red = scaled_color(int'(win_hi) - int'(mean), width);
    p.green = scaled_color(int'(mean) - int'(win_lo), width);
    p.pixel = {p.green, p.red, 8'h00};
    pending_pixels.push_back(p);
  endtask

  // send one sample request, called at a falling edge
  task automatic send_sample(input int unsigned s);
    while (!no_gaps && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'(s[SAMPLE_W-1:0]);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_sample(s[SAMPLE_W-1:0]);
    samples_sent++;
    @(negedge clk);
  endtask

  // one block of samples scattered around a target level
  task automatic send_block(input int target, input int spread);
    int v;
    for (int i = 0; i < SAMPLES; i++) begin
      v = target - spread + int'($urandom_range(2 * spread));
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      send_sample(v);
    end
  endtask

  // stop sending and let every pending pixel and any work in flight finish
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write both brightness registers, block idle
  task automatic set_colors(input logic [COLOR_W-1:0] lo, input logic [COLOR_W-1:0] hi);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_COLOR_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_COLOR_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    color_lo = lo;
    color_hi = hi;
    color_settings++;
  endtask

  // reset brightness, mean inside the window, every sample at a field extreme
  task automatic test_defaults();
    for (int i = 0; i < SAMPLES; i++)
      send_sample((i % 3 == 1) ? 0 : SAMPLE_MAX);
  endtask

  // full brightness span, mean just under the low bound replaces it
  task automatic test_low_widening();
    set_colors(8'd0, 8'd255);
    send_block(2350, 0);
  endtask

  // random blocks under one brightness setting, window widening gradually
  task automatic test_color_setting(input logic [COLOR_W-1:0] lo, input logic [COLOR_W-1:0] hi,
                                    input int blocks, input bit steady);
    int r;
    set_colors(lo, hi);
    no_gaps = steady;
    for (int b = 0; b < blocks; b++) begin
      r = $urandom_range(99);
      if (r < 40)
        send_block(int'($urandom_range(win_hi, win_lo)), int'($urandom_range(300)));
      else if (r < 55)
        send_block(int'(win_lo) - int'($urandom_range(80, 1)), int'($urandom_range(20)));
      else if (r < 70)
        send_block(int'(win_hi) + int'($urandom_range(80, 1)), int'($urandom_range(20)));
      else if (r < 82)
        send_block(($urandom_range(1) != 0) ? int'(win_lo) : int'(win_hi), 0);
      else if (r < 86)
        send_block(SAMPLE_MAX / 2, SAMPLE_MAX / 2 + 1);
      else
        send_block(int'($urandom_range(win_hi, win_lo)), 2000);
    end
    no_gaps = 1'b0;
  endtask

  // means at both ends of the sample range open the window fully
  task automatic test_full_range();
    set_colors(8'd200, 8'd3);
    send_block(SAMPLE_MAX, 0);
    send_block(0, 0);
    for (int b = 0; b < 8; b++)
      send_block(int'($urandom_range(SAMPLE_MAX)), int'($urandom_range(1500)));
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        pixel_errors++;
        if (pixel_errors <= 10)
          $display("unexpected pixel: tdata %h", out_tdata);
      end else begin
        e = pending_pixels.pop_front();
        if (out_tdata[11:0] !== e.mean || out_tdata[19:12] !== e.red ||
            out_tdata[27:20] !== e.green || out_tdata[51:28] !== e.pixel) begin
          pixel_errors++;
          if (pixel_errors <= 10)
            $display("pixel mismatch: mean %0d/%0d red %0d/%0d green %0d/%0d pixel %h/%h",
                     e.mean, out_tdata[11:0], e.red, out_tdata[19:12],
                     e.green, out_tdata[27:20], e.pixel, out_tdata[51:28]);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= no_gaps || ($urandom_range(99) >= 22);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("autoranging_level_to_color verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_COLOR_LOW;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    cycles = 0;
    samples_sent = 0;
    pixels_checked = 0;
    pixel_errors = 0;
    color_settings = 0;
    acc_sum = '0;
    acc_count = '0;
    win_lo = WINDOW_LOW_RST;
    win_hi = WINDOW_HIGH_RST;
    color_lo = COLOR_LOW_RST;
    color_hi = COLOR_HIGH_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_defaults();
    test_low_widening();
    test_color_setting(COLOR_LOW_RST, COLOR_HIGH_RST, 12, 1'b0);
    test_color_setting(8'd255, 8'd0, 12, 1'b0);
    test_color_setting(8'd0, 8'd0, 10, 1'b1);
    test_color_setting(8'd255, 8'd255, 10, 1'b0);
    test_color_setting(8'd0, 8'd255, 12, 1'b0);
    test_color_setting(COLOR_W'($urandom_range(127)), COLOR_W'($urandom_range(COLOR_MAX, 128)),
                       12, 1'b0);
    test_color_setting(COLOR_W'($urandom_range(COLOR_MAX)), COLOR_W'($urandom_range(COLOR_MAX)),
                       12, 1'b0);
    test_full_range();
    drain();

    $display("%0d samples sent, %0d pixels checked over %0d brightness settings",
             samples_sent, pixels_checked, color_settings);
    $display("final window %0d..%0d, %0d mismatches", win_lo, win_hi, pixel_errors);
    if (pixel_errors == 0 && pending_pixels.size() == 0) begin
      $display("autoranging_level_to_color verification clean");
    end else begin
      $display("autoranging_level_to_color verification failed");
    end
    $finish;
  end

endmodule

### autoranging_level_to_color.f
hw/rtl/alv_pkg.sv
hw/rtl/alv_div.sv
hw/rtl/autoranging_level_to_color.sv
hw/rtl/alv_checker.sv
tb/autoranging_level_to_color_tb.sv
